FILE: src/ccs_pkg.sv
// shared types, widths and codes for the character class scan engine
package ccs_pkg;

  // field and state widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned START_W   = 16;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned DEPTH_W   = 17;
  localparam int unsigned END_W     = 18;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned CLASS_W   = NUM_WORDS * WORD_W;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // longest string handled; a byte at this position or beyond ends the string
  localparam logic [POS_W:0] MAX_LENGTH = 18'd65536;

  // saturation limit of the nesting counter
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  // scan mode codes
  localparam logic [MODE_W-1:0] MODE_ANY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NOTANY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MANY   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPTO   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BAL    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE     = 3'd6;

  // configuration as seen by the scan logic
  typedef struct packed {
    logic [CLASS_W-1:0] class_bits;
    logic [MODE_W-1:0]  scan_mode;
    logic [BYTE_W-1:0]  open_delim;
    logic [BYTE_W-1:0]  close_delim;
  } cfg_t;

endpackage

FILE: src/ccs_if.sv
// stream interfaces for the input bytes and the scan results
interface ccs_in_if
  import ccs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_byte;
  logic [START_W-1:0] start_position;
  logic               first_of_scan;
  logic               last_of_string;
  logic               no_byte;

  modport source (
    output valid, data_byte, start_position, first_of_scan, last_of_string, no_byte,
    input  ready
  );
  modport sink (
    input  valid, data_byte, start_position, first_of_scan, last_of_string, no_byte,
    output ready
  );
endinterface

interface ccs_out_if
  import ccs_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    matched;
  logic signed [END_W-1:0] end_position;

  modport source (
    output valid, matched, end_position,
    input  ready
  );
  modport sink (
    input  valid, matched, end_position,
    output ready
  );
endinterface

FILE: src/ccs_cfg_regs.sv
// configuration registers: character class words, mode and delimiters
module ccs_cfg_regs
  import ccs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  logic [WORD_W-1:0] class_r [NUM_WORDS];
  logic [MODE_W-1:0] mode_r;
  logic [BYTE_W-1:0] open_r;
  logic [BYTE_W-1:0] close_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        class_r[i] <= '0;
      end
      mode_r  <= MODE_ANY;
      open_r  <= '0;
      close_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLASS_0:   class_r[0] <= cfg_wdata;
        CFG_CLASS_1:   class_r[1] <= cfg_wdata;
        CFG_CLASS_2:   class_r[2] <= cfg_wdata;
        CFG_CLASS_3:   class_r[3] <= cfg_wdata;
        CFG_SCAN_MODE: mode_r     <= cfg_wdata[MODE_W-1:0];
        CFG_OPEN:      open_r     <= cfg_wdata[BYTE_W-1:0];
        CFG_CLOSE:     close_r    <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // word i holds members 64*i to 64*i+63
  assign cfg.class_bits  = {class_r[3], class_r[2], class_r[1], class_r[0]};
  assign cfg.scan_mode   = mode_r;
  assign cfg.open_delim  = open_r;
  assign cfg.close_delim = close_r;

endmodule

FILE: src/ccs_scan_core.sv
// input register, per-byte scan decision and result register
module ccs_scan_core
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  ccs_in_if.sink     in_ch,
  ccs_out_if.source  out_ch
);

  // input stage
  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic [START_W-1:0] s1_start_r;
  logic               s1_first_r;
  logic               s1_last_r;
  logic               s1_none_r;

  // scan state
  logic               pending_r, pending_nxt;
  logic [POS_W-1:0]   cur_r, cur_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [MODE_W-1:0]  lmode_r, lmode_nxt;

  // result stage
  logic                    out_valid_r;
  logic                    out_matched_r;
  logic signed [END_W-1:0] out_end_r;

  logic             proc;
  logic             emit;
  logic             ok;
  logic [POS_W-1:0] epos;

  // the input stage moves on when the result slot is free or draining
  assign proc        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || proc;

  // scan decision for the byte in the input stage
  always_comb begin
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_inc;
    logic [MODE_W-1:0]  mode;
    logic [DEPTH_W-1:0] dep;
    logic               mem;
    pending_nxt = pending_r;
    cur_nxt     = cur_r;
    depth_nxt   = depth_r;
    lmode_nxt   = lmode_r;
    emit        = 1'b0;
    ok          = 1'b0;
    epos        = '0;
    pos         = s1_first_r ? {1'b0, s1_start_r} : cur_r;
    pos_inc     = pos + 1'b1;
    mode        = s1_first_r ? cfg.scan_mode : lmode_r;
    dep         = s1_first_r ? '0 : depth_r;
    mem         = cfg.class_bits[s1_byte_r];
    if (s1_first_r || pending_r) begin
      lmode_nxt   = mode;
      cur_nxt     = pos;
      depth_nxt   = dep;
      pending_nxt = 1'b0;
      if (mode > MODE_BAL) begin
        emit = 1'b1;
      end else if (s1_none_r || ({1'b0, pos} >= MAX_LENGTH)) begin
        // string ended before this byte
        emit = 1'b1;
        ok   = (mode == MODE_MANY);
        epos = pos;
      end else begin
        case (mode)
          MODE_ANY: begin
            emit = 1'b1;
            ok   = mem;
            epos = pos_inc;
          end
          MODE_NOTANY: begin
            emit = 1'b1;
            ok   = !mem;
            epos = pos_inc;
          end
          MODE_MANY: begin
            if (!mem) begin
              emit = 1'b1;
              ok   = 1'b1;
              epos = pos;
            end else begin
              cur_nxt = pos_inc;
              if (s1_last_r) begin
                emit = 1'b1;
                ok   = 1'b1;
                epos = pos_inc;
              end else begin
                pending_nxt = 1'b1;
              end
            end
          end
          MODE_UPTO: begin
            if (mem) begin
              emit = 1'b1;
              ok   = 1'b1;
              epos = pos;
            end else begin
              cur_nxt = pos_inc;
              if (s1_last_r) begin
                emit = 1'b1;
              end else begin
                pending_nxt = 1'b1;
              end
            end
          end
          default: begin
            // balanced delimiters
            if (s1_first_r) begin
              if (s1_byte_r != cfg.open_delim) begin
                emit = 1'b1;
              end else begin
                depth_nxt = {{(DEPTH_W-1){1'b0}}, 1'b1};
                cur_nxt   = pos_inc;
                if (s1_last_r) begin
                  emit = 1'b1;
                end else begin
                  pending_nxt = 1'b1;
                end
              end
            end else begin
              if (s1_byte_r == cfg.open_delim) begin
                if (dep != DEPTH_MAX) dep = dep + 1'b1;
              end else if (s1_byte_r == cfg.close_delim) begin
                if (dep != '0) dep = dep - 1'b1;
              end
              depth_nxt = dep;
              cur_nxt   = pos_inc;
              if (dep == '0) begin
                emit = 1'b1;
                ok   = 1'b1;
                epos = pos_inc;
              end else if (s1_last_r) begin
                emit = 1'b1;
              end else begin
                pending_nxt = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_start_r <= in_ch.start_position;
      s1_first_r <= in_ch.first_of_scan;
      s1_last_r  <= in_ch.last_of_string;
      s1_none_r  <= in_ch.no_byte;
    end
  end

  // scan state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      cur_r     <= '0;
      depth_r   <= '0;
      lmode_r   <= MODE_ANY;
    end else if (proc) begin
      pending_r <= pending_nxt;
      cur_r     <= cur_nxt;
      depth_r   <= depth_nxt;
      lmode_r   <= lmode_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, failure reads as minus one
  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_matched_r <= ok;
      out_end_r     <= ok ? $signed({1'b0, epos}) : '1;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.matched      = out_matched_r;
  assign out_ch.end_position = out_end_r;

  // a failed scan always reports minus one
  a_fail_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_matched_r |-> out_end_r == '1)
    else $error("failure result without minus one position");

  // a successful scan never reports a negative position
  a_ok_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_matched_r |-> !out_end_r[END_W-1])
    else $error("successful result with negative position");

  // only multi-byte modes keep a scan open
  a_pending_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (lmode_r == MODE_MANY || lmode_r == MODE_UPTO || lmode_r == MODE_BAL))
    else $error("scan pending in a single-byte mode");

  // an open balanced scan is inside at least one level
  a_bal_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r && lmode_r == MODE_BAL |-> depth_r != '0)
    else $error("balanced scan pending at depth zero");

  // an open scan never points past the string limit
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> {1'b0, cur_r} <= MAX_LENGTH)
    else $error("pending scan position beyond the limit");

endmodule

FILE: src/char_class_scan_engine.sv
// top level of the character class scan engine
//
// Bytes of a string arrive on in_ch, one per transfer, from the scan start
// onward; first_of_scan opens a scan and latches scan_mode and the start
// position, no_byte stands for a start at or past the string end.
// Each scan gives one transfer on out_ch (matched, end_position, -1 on
// failure) at the byte that decides it; later bytes of that scan are
// dropped until the next first_of_scan.
// The class words, mode and delimiters are written through cfg_we,
// cfg_index and cfg_wdata; the user does so only while no scan is in
// flight, which the block itself does not enforce. The deciding byte
// is held in the input register, its result in the result register.
// Throughput: one byte per cycle when out_ch does not stall; each byte costs
// one class bit lookup, two delimiter compares and one position and depth update.
// Reset clears the configuration to zero, drops any open scan and empties
// both registers. When out_ch stalls the result holds and the input
// register takes one more byte before in_ch.ready drops.
module char_class_scan_engine
  import ccs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ccs_in_if.sink               in_ch,
  ccs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  cfg_t cfg;

  // configuration registers
  ccs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // scan datapath
  ccs_scan_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
